### rtl/fcal_pkg.sv
// Shared types and constants for the fixed capacity array list.
package fcal_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 4;
    localparam int POS_W        = 5;
    localparam int STAT_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_POS  = 4'd0,
        CMD_INS_HEAD = 4'd1,
        CMD_INS_REAR = 4'd2,
        CMD_DEL_POS  = 4'd3,
        CMD_DEL_VAL  = 4'd4,
        CMD_DEL_HEAD = 4'd5,
        CMD_CLEAR    = 4'd6,
        CMD_READ     = 4'd7,
        CMD_FIND     = 4'd8
    } cmd_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_e_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_DELETE,
        MODE_CLEAR
    } mode_e_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        mode_e_t                  mode;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

### rtl/fcal_if.sv
// Command and response channel interfaces for the array list.
interface fcal_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [fcal_pkg::CMD_W-1:0]       command;
    logic [fcal_pkg::POS_W-1:0]       position;
    logic signed [fcal_pkg::DATA_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface fcal_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [fcal_pkg::STAT_W-1:0]        status;
    logic signed [fcal_pkg::DATA_W-1:0] read_value;
    logic [fcal_pkg::POS_W-1:0]         found_position;
    logic [fcal_pkg::POS_W-1:0]         list_length;
    logic                               is_empty;
    logic                               is_full;

    modport source (output valid, status, read_value, found_position, list_length,
                    is_empty, is_full, input ready);
    modport sink   (input valid, status, read_value, found_position, list_length,
                    is_empty, is_full, output ready);
endinterface

### rtl/fcal_cell.sv
// One list slot: holds an entry and shifts with its neighbors on insert or delete.
module fcal_cell (
    input  logic                              clk,
    input  fcal_pkg::cell_ctl_t               ctl,
    input  logic                              ge,
    input  logic                              eq,
    input  logic signed [fcal_pkg::DATA_W-1:0] prev_data,
    input  logic signed [fcal_pkg::DATA_W-1:0] next_data,
    output logic signed [fcal_pkg::DATA_W-1:0] data,
    output logic                              match
);
    import fcal_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.mode)
            MODE_INSERT:
            begin
                if (eq)
                    data_next = ctl.value;
                else if (ge)
                    data_next = prev_data;
            end
            MODE_DELETE:
            begin
                if (ge)
                    data_next = next_data;
            end
            MODE_CLEAR:  data_next = '0;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == ctl.value);

endmodule

### rtl/fixed_capacity_array_list.sv
// Ordered list of signed 32-bit entries built as a chain of shifting cells.
//
// Commands enter on the cmd channel (command, position, value) and each one
// gives exactly one response item on rsp: status, read value, found position,
// list length and empty/full flags after the command.
//
// Every command reaches the response register through per-cell compare,
// prefix/decision, then the cell chain and response register update together.
// The prefix/decision stage (the prefix is a log-depth OR scan over the match
// bits that locates the first matching cell) has a state of its own; the next
// command is taken in the idle state only, once the last response is
// registered. cmd.ready is high only while no command is in work.
//
// The response sits in an output register. A new command is accepted while
// that response waits; if the receiver still stalls when the next command
// reaches its update cycle, the update holds until the register frees up.
//
// Reset empties the list (length zero); entry contents are not cleared and
// are never reported before being written.
module fixed_capacity_array_list #(
    parameter int CAPACITY = fcal_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fcal_cmd_if.sink   cmd,
    fcal_rsp_if.source rsp
);
    import fcal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_PFX,
        S_APPLY
    } state_t;

    state_t                   state_reg;
    logic [CMD_W-1:0]         cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CW-1:0]            count_reg;
    logic [CAPACITY-1:0]      match_reg;
    logic [CAPACITY-1:0]      ge_reg;
    logic [CAPACITY-1:0]      eq_reg;
    mode_e_t                  mode_reg;
    status_e_t                status_reg;

    logic                     out_valid_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic signed [DATA_W-1:0] out_read_reg;
    logic [POS_W-1:0]         out_found_reg;
    logic [POS_W-1:0]         out_len_reg;
    logic                     out_empty_reg;
    logic                     out_full_reg;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;
    cell_ctl_t                cell_ctl;

    logic [CAPACITY-1:0]      live;
    logic [CAPACITY-1:0]      match_next;
    logic [CAPACITY-1:0]      ge_next;
    logic [CAPACITY-1:0]      eq_next;
    logic [CAPACITY-1:0]      ge_pos;
    mode_e_t                  mode_next;
    status_e_t                status_next;
    logic [CW-1:0]            at_idx;
    logic                     use_pfx;
    logic                     any_match;
    logic                     ins_ok;
    logic                     del_ok;
    logic                     is_full_now;
    logic                     is_empty_now;
    logic [PW-1:0]            pos_ext;
    logic [PW-1:0]            cnt_ext;

    logic                     can_emit;
    logic                     emit;
    logic [CW-1:0]            count_next;
    logic signed [DATA_W-1:0] sel_data;
    logic [IW-1:0]            sel_idx;
    logic signed [DATA_W-1:0] read_next;
    logic [POS_W-1:0]         found_next;

    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] m);
        logic [CAPACITY-1:0] p;
        p = m;
        for (int s = 1; s < CAPACITY; s = s * 2)
            p = p | (p << s);
        return p;
    endfunction

    // cell chain
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_d;
        logic signed [DATA_W-1:0] next_d;
        if (j == 0)
        begin : g_first
            assign prev_d = '0;
        end
        else
        begin : g_mid_p
            assign prev_d = cell_data[j-1];
        end
        if (j == CAPACITY - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_mid_n
            assign next_d = cell_data[j+1];
        end

        fcal_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .ge        (ge_reg[j]),
            .eq        (eq_reg[j]),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[j]),
            .match     (cell_match[j])
        );
    end

    // compare stage: only occupied slots may match
    always_comb
    begin
        for (int j = 0; j < CAPACITY; j++)
            live[j] = (CW'(j) < count_reg);
        match_next = cell_match & live;
    end

    // decision stage
    always_comb
    begin
        pos_ext      = PW'(pos_reg);
        cnt_ext      = PW'(count_reg);
        any_match    = |match_reg;
        ins_ok       = (pos_reg != '0) && (pos_ext <= cnt_ext + PW'(1));
        del_ok       = (pos_reg != '0) && (pos_ext <= cnt_ext);
        is_full_now  = (count_reg >= CW'(CAPACITY));
        is_empty_now = (count_reg == '0);
        at_idx       = CW'(pos_ext - PW'(1));
        use_pfx      = 1'b0;
        mode_next    = MODE_HOLD;
        status_next  = ST_OK;

        case (cmd_reg)
            CMD_INS_POS:
            begin
                if (!ins_ok)
                    status_next = ST_BADPOS;
                else if (is_full_now)
                    status_next = ST_FULL;
                else
                    mode_next = MODE_INSERT;
            end
            CMD_INS_HEAD:
            begin
                at_idx = '0;
                if (is_full_now)
                    status_next = ST_FULL;
                else
                    mode_next = MODE_INSERT;
            end
            CMD_INS_REAR:
            begin
                at_idx = count_reg;
                if (is_full_now)
                    status_next = ST_FULL;
                else
                    mode_next = MODE_INSERT;
            end
            CMD_DEL_POS:
            begin
                if (!del_ok)
                    status_next = ST_BADPOS;
                else
                    mode_next = MODE_DELETE;
            end
            CMD_DEL_VAL:
            begin
                use_pfx = 1'b1;
                if (is_empty_now)
                    status_next = ST_EMPTY;
                else if (!any_match)
                    status_next = ST_NOTFOUND;
                else
                    mode_next = MODE_DELETE;
            end
            CMD_DEL_HEAD:
            begin
                at_idx = '0;
                if (is_empty_now)
                    status_next = ST_EMPTY;
                else
                    mode_next = MODE_DELETE;
            end
            CMD_CLEAR:
            begin
                mode_next = MODE_CLEAR;
            end
            CMD_READ:
            begin
                if (!del_ok)
                    status_next = ST_BADPOS;
            end
            CMD_FIND:
            begin
                use_pfx = 1'b1;
                if (!any_match)
                    status_next = ST_NOTFOUND;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        for (int j = 0; j < CAPACITY; j++)
            ge_pos[j] = (CW'(j) >= at_idx);
        ge_next = use_pfx ? prefix_or(match_reg) : ge_pos;
        // first cell of the shifted region
        eq_next = ge_next & ~(ge_next << 1);
    end

    // update stage
    always_comb
    begin
        can_emit = !out_valid_reg || rsp.ready;
        emit     = (state_reg == S_APPLY) && can_emit;

        cell_ctl.value = value_reg;
        cell_ctl.mode  = emit ? mode_reg : MODE_HOLD;

        case (mode_reg)
            MODE_INSERT: count_next = count_reg + CW'(1);
            MODE_DELETE: count_next = count_reg - CW'(1);
            MODE_CLEAR:  count_next = '0;
            default:     count_next = count_reg;
        endcase

        sel_data = '0;
        sel_idx  = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            sel_data = sel_data | (cell_data[j] & {DATA_W{eq_reg[j]}});
            sel_idx  = sel_idx | (IW'(j) & {IW{eq_reg[j]}});
        end

        read_next  = ((cmd_reg == CMD_READ) && (status_reg == ST_OK)) ? sel_data : '0;
        found_next = ((cmd_reg == CMD_FIND) && (status_reg == ST_OK))
                   ? POS_W'(POS_W'(sel_idx) + POS_W'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            pos_reg        <= '0;
            value_reg      <= '0;
            count_reg      <= '0;
            match_reg      <= '0;
            ge_reg         <= '0;
            eq_reg         <= '0;
            mode_reg       <= MODE_HOLD;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_read_reg   <= '0;
            out_found_reg  <= '0;
            out_len_reg    <= '0;
            out_empty_reg  <= 1'b1;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg   <= cmd.command;
                        pos_reg   <= cmd.position;
                        value_reg <= cmd.value;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    match_reg <= match_next;
                    state_reg <= S_PFX;
                end
                S_PFX:
                begin
                    ge_reg     <= ge_next;
                    eq_reg     <= eq_next;
                    mode_reg   <= mode_next;
                    status_reg <= status_next;
                    state_reg  <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (can_emit)
                    begin
                        count_reg      <= count_next;
                        out_status_reg <= status_reg;
                        out_read_reg   <= read_next;
                        out_found_reg  <= found_next;
                        out_len_reg    <= POS_W'(count_next);
                        out_empty_reg  <= (count_next == '0);
                        out_full_reg   <= (count_next >= CW'(CAPACITY));
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_value     = out_read_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.list_length    = out_len_reg;
    assign rsp.is_empty       = out_empty_reg;
    assign rsp.is_full        = out_full_reg;

endmodule

### sim/fixed_capacity_array_list_tb.sv
// Testbench for the fixed capacity array list: directed table, then random commands.
module fixed_capacity_array_list_tb;

    import fcal_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int RAND_ITEMS = 600;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] rd;
        logic [POS_W-1:0]         fpos;
        logic [POS_W-1:0]         len;
        logic                     empty;
        logic                     full;
    } list_rsp_t;

    typedef struct {
        logic [CMD_W-1:0]         c;
        logic [POS_W-1:0]         p;
        logic signed [DATA_W-1:0] v;
        int                       reps;
        bit                       typed;
        list_rsp_t                want;
    } step_row_t;

    logic clk;
    logic rst_n;

    fcal_cmd_if cmd_if ();
    fcal_rsp_if rsp_if ();

    fixed_capacity_array_list #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the list
    logic signed [DATA_W-1:0] shadow_list [CAP];
    int                       shadow_len;

    list_rsp_t pending_rsp [$];
    step_row_t dir_tab [$];

    int  mismatch_cnt;
    int  rsp_seen;
    int  cmd_sent;
    int  full_hits;
    int  empty_hits;
    int  miss_hits;
    int  badpos_hits;
    bit  send_calm;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic void open_at(int at, logic signed [DATA_W-1:0] v);
        for (int j = shadow_len; j > at; j--)
            shadow_list[j] = shadow_list[j-1];
        shadow_list[at] = v;
        shadow_len++;
    endfunction

    function automatic void drop_at(int at);
        for (int j = at; j + 1 < shadow_len; j++)
            shadow_list[j] = shadow_list[j+1];
        shadow_len--;
    endfunction

    function automatic list_rsp_t list_apply(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                                             logic signed [DATA_W-1:0] v);
        list_rsp_t r;
        int        pi;
        int        at;
        r  = '0;
        pi = int'(p);
        at = -1;
        for (int j = 0; j < shadow_len; j++)
        begin
            if (shadow_list[j] == v)
            begin
                at = j;
                break;
            end
        end
        case (c)
            CMD_INS_POS:
                if (pi < 1 || pi > shadow_len + 1)
                    r.status = ST_BADPOS;
                else if (shadow_len >= CAP)
                    r.status = ST_FULL;
                else
                    open_at(pi - 1, v);
            CMD_INS_HEAD:
                if (shadow_len >= CAP)
                    r.status = ST_FULL;
                else
                    open_at(0, v);
            CMD_INS_REAR:
                if (shadow_len >= CAP)
                    r.status = ST_FULL;
                else
                    open_at(shadow_len, v);
            CMD_DEL_POS:
                if (pi < 1 || pi > shadow_len)
                    r.status = ST_BADPOS;
                else
                    drop_at(pi - 1);
            CMD_DEL_VAL:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (at < 0)
                    r.status = ST_NOTFOUND;
                else
                    drop_at(at);
            CMD_DEL_HEAD:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    drop_at(0);
            CMD_CLEAR:
            begin
                for (int j = 0; j < CAP; j++)
                    shadow_list[j] = '0;
                shadow_len = 0;
            end
            CMD_READ:
                if (pi < 1 || pi > shadow_len)
                    r.status = ST_BADPOS;
                else
                    r.rd = shadow_list[pi-1];
            CMD_FIND:
                if (at < 0)
                    r.status = ST_NOTFOUND;
                else
                    r.fpos = POS_W'(at + 1);
            default: ;
        endcase
        r.len   = POS_W'(shadow_len);
        r.empty = (shadow_len == 0);
        r.full  = (shadow_len >= CAP);
        return r;
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                           input logic signed [DATA_W-1:0] v, input int reps,
                           input bit typed, input logic [STAT_W-1:0] st,
                           input logic signed [DATA_W-1:0] rd, input logic [POS_W-1:0] fp,
                           input logic [POS_W-1:0] len);
        step_row_t row;
        row.c           = c;
        row.p           = p;
        row.v           = v;
        row.reps        = reps;
        row.typed       = typed;
        row.want.status = st;
        row.want.rd     = rd;
        row.want.fpos   = fp;
        row.want.len    = len;
        row.want.empty  = (len == 0);
        row.want.full   = (len == CAP);
        dir_tab.push_back(row);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                            input logic signed [DATA_W-1:0] v, input bit typed,
                            input list_rsp_t want);
        int        g;
        list_rsp_t r;
        g = send_calm ? 0 : $urandom_range(0, 12);
        if (g > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= c;
        cmd_if.position <= p;
        cmd_if.value    <= v;
        do @(posedge clk); while (!cmd_if.ready);
        r = list_apply(c, p, v);
        pending_rsp.push_back(typed ? want : r);
        cmd_sent++;
        if (r.full)
            full_hits++;
        case (r.status)
            ST_EMPTY:    empty_hits++;
            ST_NOTFOUND: miss_hits++;
            ST_BADPOS:   badpos_hits++;
            default: ;
        endcase
    endtask

    function automatic void check_rsp();
        list_rsp_t got;
        list_rsp_t w;
        got.status = rsp_if.status;
        got.rd     = rsp_if.read_value;
        got.fpos   = rsp_if.found_position;
        got.len    = rsp_if.list_length;
        got.empty  = rsp_if.is_empty;
        got.full   = rsp_if.is_full;
        rsp_seen++;
        if (pending_rsp.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("response %0d with none expected: st=%0d rd=%0d fp=%0d len=%0d",
                         rsp_seen, got.status, got.rd, got.fpos, got.len);
            return;
        end
        w = pending_rsp.pop_front();
        if (got !== w)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
            begin
                $display("response %0d mismatch:", rsp_seen);
                $display("  exp st=%0d rd=%0d fp=%0d len=%0d e=%0b f=%0b",
                         w.status, w.rd, w.fpos, w.len, w.empty, w.full);
                $display("  got st=%0d rd=%0d fp=%0d len=%0d e=%0b f=%0b",
                         got.status, got.rd, got.fpos, got.len, got.empty, got.full);
            end
        end
    endfunction

    // response side
    initial begin
        int g;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            g = (((rsp_seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 12);
            if (g > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            check_rsp();
        end
    end

    initial begin
        logic [CMD_W-1:0]         c;
        logic [POS_W-1:0]         p;
        logic signed [DATA_W-1:0] v;
        int                       r;
        int                       ins_w;
        int                       del_w;
        int                       dir_items;

        mismatch_cnt = 0;
        rsp_seen     = 0;
        cmd_sent     = 0;
        full_hits    = 0;
        empty_hits   = 0;
        miss_hits    = 0;
        badpos_hits  = 0;
        send_calm    = 1'b0;
        shadow_len   = 0;
        for (int j = 0; j < CAP; j++)
            shadow_list[j] = '0;

        rst_n           <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.command  <= '0;
        cmd_if.position <= '0;
        cmd_if.value    <= '0;

        // empty list corner cases
        add_row(CMD_READ,     5'd1,  32'sd0,  1, 1, ST_BADPOS,   0, 0, 0);
        add_row(CMD_DEL_HEAD, 5'd0,  32'sd0,  1, 1, ST_EMPTY,    0, 0, 0);
        add_row(CMD_DEL_VAL,  5'd0,  32'sd0,  1, 1, ST_EMPTY,    0, 0, 0);
        add_row(CMD_FIND,     5'd0,  32'sd0,  1, 1, ST_NOTFOUND, 0, 0, 0);
        add_row(CMD_INS_POS,  5'd0,  32'sd5,  1, 1, ST_BADPOS,   0, 0, 0);
        add_row(CMD_INS_POS,  5'd2,  32'sd5,  1, 1, ST_BADPOS,   0, 0, 0);
        // build a short list with extreme values
        add_row(CMD_INS_POS,  5'd1,  32'sh8000_0000, 1, 1, ST_OK, 0, 0, 1);
        add_row(CMD_INS_HEAD, 5'd0,  32'sh7fff_ffff, 1, 1, ST_OK, 0, 0, 2);
        add_row(CMD_INS_REAR, 5'd0,  -32'sd1, 1, 1, ST_OK, 0, 0, 3);
        add_row(CMD_INS_POS,  5'd2,  32'sd0,  1, 0, ST_OK, 0, 0, 0);
        add_row(CMD_READ,     5'd1,  32'sd0,  1, 1, ST_OK, 32'sh7fff_ffff, 0, 4);
        add_row(CMD_READ,     5'd4,  32'sd0,  1, 1, ST_OK, -32'sd1, 0, 4);
        add_row(CMD_FIND,     5'd0,  32'sh8000_0000, 1, 0, ST_OK, 0, 0, 0);
        add_row(CMD_DEL_VAL,  5'd0,  32'sd12345, 1, 1, ST_NOTFOUND, 0, 0, 4);
        add_row(CMD_DEL_POS,  5'd5,  32'sd0,  1, 1, ST_BADPOS,   0, 0, 4);
        add_row(CMD_DEL_VAL,  5'd0,  32'sd0,  1, 0, ST_OK, 0, 0, 0);
        add_row(CMD_SPARE_HI, 5'd31, -32'sd1, 1, 1, ST_OK, 0, 0, 3);
        add_row(CMD_SPARE_LO, 5'd0,  32'sd0,  1, 0, ST_OK, 0, 0, 0);
        // fill up, then hit the full cases
        add_row(CMD_INS_REAR, 5'd0,  32'sd100, 13, 0, ST_OK, 0, 0, 0);
        add_row(CMD_INS_HEAD, 5'd0,  32'sd7,  1, 1, ST_FULL,   0, 0, 16);
        add_row(CMD_INS_POS,  5'd17, 32'sd7,  1, 1, ST_FULL,   0, 0, 16);
        add_row(CMD_INS_POS,  5'd31, 32'sd7,  1, 1, ST_BADPOS, 0, 0, 16);
        add_row(CMD_READ,     5'd16, 32'sd0,  1, 0, ST_OK, 0, 0, 0);
        add_row(CMD_DEL_HEAD, 5'd0,  32'sd0,  1, 0, ST_OK, 0, 0, 0);
        add_row(CMD_CLEAR,    5'd0,  32'sd0,  1, 1, ST_OK, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            for (int k = 0; k < dir_tab[i].reps; k++)
                send_cmd(dir_tab[i].c, dir_tab[i].p, dir_tab[i].v + k,
                         dir_tab[i].typed, dir_tab[i].want);
        dir_items = cmd_sent;

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            send_calm = ((i / 40) % 4) == 1;
            // drain everything once mid run
            if (i == RAND_ITEMS / 2)
            begin
                cmd_if.valid <= 1'b0;
                do @(posedge clk); while (pending_rsp.size() != 0);
            end
            // alternate between growing, shrinking and mixed phases
            case ((i / 100) % 3)
                0:       begin ins_w = 55; del_w = 15; end
                1:       begin ins_w = 15; del_w = 55; end
                default: begin ins_w = 35; del_w = 35; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 3)
                c = CMD_SPARE_LO + CMD_W'($urandom_range(0, 6));
            else if (r < 5)
                c = CMD_CLEAR;
            else if (r < 5 + ins_w)
                c = CMD_INS_POS + CMD_W'($urandom_range(0, 2));
            else if (r < 5 + ins_w + del_w)
                c = CMD_DEL_POS + CMD_W'($urandom_range(0, 2));
            else
                c = ($urandom_range(0, 1) != 0) ? CMD_READ : CMD_FIND;

            if ($urandom_range(0, 99) < 15)
                p = POS_W'($urandom_range(0, 31));
            else if (c == CMD_INS_POS)
                p = POS_W'($urandom_range(1, shadow_len + 1));
            else
                p = POS_W'($urandom_range(1, (shadow_len > 0) ? shadow_len : 1));

            r = $urandom_range(0, 9);
            if (r < 5 && shadow_len > 0)
                v = shadow_list[$urandom_range(0, shadow_len - 1)];
            else if (r < 7)
                v = $signed($urandom_range(0, 6)) - 3;
            else if (r < 8)
                v = ($urandom_range(0, 1) != 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            else
                v = $urandom;

            send_cmd(c, p, v, 1'b0, '0);
        end

        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
        repeat (16) @(posedge clk);

        $display("%0d commands (%0d from the table), %0d responses, %0d mismatches",
                 cmd_sent, dir_items, rsp_seen, mismatch_cnt);
        $display("list full %0d times; empty %0d, not found %0d, bad position %0d statuses",
                 full_hits, empty_hits, miss_hits, badpos_hits);
        if (mismatch_cnt == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/fcal_pkg.sv
rtl/fcal_if.sv
rtl/fcal_cell.sv
rtl/fixed_capacity_array_list.sv
sim/fixed_capacity_array_list_tb.sv
